>>> rtl/core/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } core_ctl_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS  = 7'd56;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
            32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
            32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
            32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
            32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
            32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
            32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
            32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
            32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
            32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
            32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[idx];
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h [8];
        h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return h[idx];
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/sha256_round.sv
`default_nettype none
module sha256_round (
    input  wire                   clk,
    input  wire                   rst_n,
    input  sha256_pkg::core_ctl_t ctl_in,
    input  wire  [511:0]          block,
    output sha256_pkg::core_ctl_t ctl_out,
    output logic [255:0]          hash,
    input  wire                   hash_init
);
    import sha256_pkg::*;

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  round_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] w15, w2, w7, s0, s1, w_new, w_cur;
    logic [31:0] e1, ch, a0, maj, t1, t2;

    // schedule word: the window head up to round 15, then w_new
    assign w15   = w_reg[1];
    assign w2    = w_reg[14];
    assign w7    = w_reg[9];
    assign s0    = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
    assign s1    = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
    assign w_new = w_reg[0] + s0 + w7 + s1;
    assign w_cur = (round_reg < 6'd16) ? w_reg[0] : w_new;

    assign e1  = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
               ^ {v_reg[4][24:0], v_reg[4][31:25]};
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign a0  = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
               ^ {v_reg[0][21:0], v_reg[0][31:22]};
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + e1 + ch + round_k(round_reg) + w_cur;
    assign t2  = a0 + maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= init_h(3'(i));
                v_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (hash_init)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= init_h(3'(i));
                end
            end
            if (ctl_in.start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            else if (busy_reg)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (done_reg)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
        end
    end

    // window shifts one word per round; new word enters at the tail
    always_ff @(posedge clk)
    begin
        if (ctl_in.start && !busy_reg)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32*i -: 32];
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_cur;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            hash[255 - 32*i -: 32] = h_reg[i];
        end
    end

    // done pulses one cycle; chaining update lands the cycle after
    assign ctl_out.start = 1'b0;
    assign ctl_out.busy  = busy_reg || done_reg;
    assign ctl_out.done  = done_reg;

    a_round_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && round_reg == 6'd63 |=> done_reg && !busy_reg)
        else $error("round counter did not finish block");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("done while busy");
    a_round_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_in.start && !busy_reg && !done_reg |=> busy_reg && round_reg == 6'd0)
        else $error("start did not launch rounds");

endmodule
`default_nettype wire

>>> rtl/core/sha256_message_hasher.sv
`default_nettype none
// Sequence: a byte without end is only buffered; a byte that fills a block also
// runs a compression (start, 64 rounds in the shared round unit, chaining update).
// End of message: the padding is written and one compression runs, or, if the length
// does not fit, the length block is written and a second compression runs;
// then 8 digest transfers, one per cycle at best, held while m_tready is low.
// Throughput: 1 byte per cycle within a block, none while a block is compressed.
// Reset (rst_n low, async): initial hash values, empty buffer, zero bit count.
module sha256_message_hasher (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] data_byte
    input  wire  [1:0]  s_tuser,   // [0] byte_present, [1] end_of_message
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        m_tlast    // last_word
);
    import sha256_pkg::*;

    state_t       state_reg, state_next;
    logic [31:0]  buf_reg [16];  // block held as big-endian words
    logic [6:0]   fill_reg;
    logic [63:0]  bits_reg;
    logic         fin_reg;      // end seen
    logic         padded_reg;   // pad marker and zeros written
    logic         second_reg;   // length block still to go
    logic [2:0]   oidx_reg;
    logic [511:0] block;
    logic [255:0] hash;
    core_ctl_t    ctl_in, ctl_out;
    logic         take, hash_init;
    logic [5:0]   fpos;
    logic         len_fits;     // length fits behind the pad marker in this block

    assign take     = s_tvalid && s_tready;
    assign fpos     = fill_reg[5:0];
    assign len_fits = (fill_reg + 7'd1) <= LEN_POS;

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            block[511 - 32*i -: 32] = buf_reg[i];
        end
    end

    sha256_round u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_in),
        .block     (block),
        .ctl_out   (ctl_out),
        .hash      (hash),
        .hash_init (hash_init)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state: ST_ROUND waits for the round unit, ST_FINAL writes the padding,
    // ST_PAD writes the length block, ST_OUT streams eight words
    always_comb
    begin
        state_next   = state_reg;
        ctl_in       = '0;
        s_tready     = 1'b0;
        hash_init    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (take)
                begin
                    if (s_tuser[0] && fill_reg == 7'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (s_tuser[1])
                    begin
                        state_next = ST_FINAL;
                    end
                end
            end
            ST_ROUND:
            begin
                ctl_in.start = !ctl_out.busy;
                if (ctl_out.done)
                begin
                    priority if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!padded_reg)
                    begin
                        state_next = ST_FINAL;
                    end
                    else if (second_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_FINAL:
            begin
                state_next = ST_ROUND;
            end
            ST_PAD:
            begin
                state_next = ST_ROUND;
            end
            ST_OUT:
            begin
                if (m_tready && oidx_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                    hash_init  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath bookkeeping; the buffer entries need no reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            bits_reg   <= '0;
            fin_reg    <= 1'b0;
            padded_reg <= 1'b0;
            second_reg <= 1'b0;
            oidx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        fin_reg    <= s_tuser[1];
                        padded_reg <= 1'b0;
                        second_reg <= 1'b0;
                        if (s_tuser[0])
                        begin
                            fill_reg <= (fill_reg == 7'd63) ? 7'd0 : fill_reg + 7'd1;
                            bits_reg <= bits_reg + 64'd8;
                        end
                    end
                end
                ST_ROUND:
                begin
                end
                ST_FINAL:
                begin
                    // pad marker written now; a second block when the length does not fit
                    padded_reg <= 1'b1;
                    second_reg <= !len_fits;
                    fill_reg   <= '0;
                    oidx_reg   <= '0;
                end
                ST_PAD:
                begin
                    second_reg <= 1'b0;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            bits_reg   <= '0;
                            fin_reg    <= 1'b0;
                            padded_reg <= 1'b0;
                            second_reg <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // buffer writes: byte, pad marker and zeros, length bytes
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && take && s_tuser[0])
        begin
            buf_reg[fpos[5:2]][{~fpos[1:0], 3'b000} +: 8] <= s_tdata;
        end
        else if (state_reg == ST_FINAL)
        begin
            for (int wi = 0; wi < 16; wi++)
            begin
                for (int bi = 0; bi < 4; bi++)
                begin
                    if (7'(4*wi + bi) == fill_reg)
                    begin
                        buf_reg[wi][31 - 8*bi -: 8] <= PAD_BYTE;
                    end
                    else if (7'(4*wi + bi) > fill_reg)
                    begin
                        if (len_fits && wi >= 14)
                        begin
                            buf_reg[wi][31 - 8*bi -: 8] <= bits_reg[8*(63 - 4*wi - bi) +: 8];
                        end
                        else
                        begin
                            buf_reg[wi][31 - 8*bi -: 8] <= 8'h00;
                        end
                    end
                end
            end
        end
        else if (state_reg == ST_PAD)
        begin
            for (int i = 0; i < 14; i++)
            begin
                buf_reg[i] <= 32'h0;
            end
            buf_reg[14] <= bits_reg[63:32];
            buf_reg[15] <= bits_reg[31:0];
        end
    end

    // chaining update lands in the cycle after done, so hold output until ST_OUT
    assign m_tvalid = (state_reg == ST_OUT) && !ctl_out.busy;
    assign m_tlast  = (oidx_reg == 3'd7);
    assign m_tdata  = {5'd0, oidx_reg, hash[255 - 32*oidx_reg -: 32]};

    a_out_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> state_reg == ST_OUT)
        else $error("digest transfer outside output phase");
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !ctl_out.busy)
        else $error("input ready while rounds run");
    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> state_reg == ST_IDLE && bits_reg == 64'd0)
        else $error("state not cleared after digest");

endmodule
`default_nettype wire

>>> dv/sha256_digest_checker.sv
module sha256_digest_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [7:0]  s_tdata,
    input  wire  [1:0]  s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [39:0] m_tdata,
    input  wire         m_tlast,
    output int          fail_count,
    output int          pending_words
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,
        32'h3956c25b,32'h59f111f1,32'h923f82a4,32'hab1c5ed5,
        32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,
        32'he49b69c1,32'hefbe4786,32'h0fc19dc6,32'h240ca1cc,
        32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,
        32'hc6e00bf3,32'hd5a79147,32'h06ca6351,32'h14292967,
        32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,
        32'ha2bfe8a1,32'ha81a664b,32'hc24b8b70,32'hc76c51a3,
        32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,
        32'h391c0cb3,32'h4ed8aa4a,32'h5b9cca4f,32'h682e6ff3,
        32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    localparam logic [31:0] IV [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    int           block_fill;
    logic [63:0]  bit_length;
    digest_item_t digest_queue [$];

    assign pending_words = digest_queue.size();

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        v = hash_state;
        for (int r = 0; r < 64; r++)
        begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + w[r];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    // Absorb one accepted input transfer; queue the digest on end of message.
    task automatic absorb(logic [7:0] b, logic present, logic eom);
        digest_item_t d;
        if (present)
        begin
            msg_block[block_fill] = b;
            block_fill++;
            bit_length += 64'd8;
            if (block_fill == 64)
            begin
                compress();
                block_fill = 0;
            end
        end
        if (!eom)
            return;
        msg_block[block_fill] = 8'h80;
        block_fill++;
        if (block_fill > 56)
        begin
            for (int i = block_fill; i < 64; i++)
                msg_block[i] = 8'h00;
            compress();
            block_fill = 0;
        end
        for (int i = block_fill; i < 56; i++)
            msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[63-i] = bit_length[8*i +: 8];
        compress();
        for (int i = 0; i < 8; i++)
        begin
            d.word = hash_state[i];
            d.index = 3'(i);
            d.last = (i == 7);
            digest_queue.push_back(d);
        end
        hash_state = IV;
        block_fill = 0;
        bit_length = '0;
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        hash_state = IV;
        block_fill = 0;
        bit_length = '0;
    end

    always @(posedge clk)
    begin
        digest_item_t d;
        if (rst_n && s_tvalid && s_tready)
            absorb(s_tdata, s_tuser[0], s_tuser[1]);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digest_queue.size() == 0)
                report("unexpected transfer", m_tdata, 0);
            else
            begin
                d = digest_queue.pop_front();
                if (m_tdata[31:0] !== d.word)
                    report("digest_word", m_tdata[31:0], d.word);
                if (m_tdata[34:32] !== d.index)
                    report("word_index", m_tdata[34:32], d.index);
                if (m_tdata[39:35] !== 5'd0)
                    report("tdata pad", m_tdata[39:35], 0);
                if (m_tlast !== d.last)
                    report("last_word", m_tlast, d.last);
            end
        end
    end
endmodule

>>> dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [7:0] data_byte
    logic [1:0]  s_tuser;     // [0] byte_present, [1] end_of_message
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // [31:0] digest_word, [34:32] word_index
    logic        m_tlast;
    int          fail_count;
    int          pending_words;
    int          idle_cycles;
    bit          hold_off;

    sha256_message_hasher DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    sha256_digest_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Offer one transfer at the falling edge and hold it until accepted.
    // Transfers come in bursts: while the burst counter is nonzero no idle is inserted.
    int burst_left;
    task automatic send(logic [7:0] b, logic present, logic eom);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            burst_left = $urandom_range(1, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= {eom, present};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Message of len bytes; some messages end with a byte on the end transfer,
    // others with a separate empty end transfer. Stray empty transfers mixed in.
    task automatic send_message(int len, bit fixed_byte, logic [7:0] fill);
        bit end_on_byte;
        logic [7:0] b;
        end_on_byte = (len > 0) && $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
        begin
            b = fixed_byte ? fill : 8'($urandom);
            if ($urandom_range(0, 15) == 0)
                send(8'($urandom), 1'b0, 1'b0);
            send(b, 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte)
            send(8'($urandom), 1'b0, 1'b1);
    endtask

    // Receiver: random stall pattern, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: count cycles without any accepted transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT && !hold_off)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int sent;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        idle_cycles = 0;
        burst_left = 0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, single bytes at the extremes, padding boundaries.
        send_message(0, 1'b1, 8'h00);
        send_message(1, 1'b1, 8'h00);
        send_message(1, 1'b1, 8'hff);
        send_message(3, 1'b0, 8'h00);
        send(8'hab, 1'b1, 1'b1);
        send_message(55, 1'b1, 8'h5a);
        send_message(56, 1'b1, 8'ha5);
        send_message(63, 1'b0, 8'h00);
        send_message(64, 1'b1, 8'hff);

        // Long hold-off on the receiver while messages keep coming.
        fork
            begin
                hold_off = 1'b1;
                repeat (600) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                send_message(2, 1'b0, 8'h00);
                send_message(1, 1'b0, 8'h00);
                send_message(0, 1'b0, 8'h00);
            end
        join

        // Random: mostly short messages of up to 20 bytes, a few of 56 to 130 bytes.
        sent = 0;
        while (sent < 240)
        begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 130)
                                              : $urandom_range(0, 20);
            send_message(len, 1'b0, 8'h00);
            sent += len + 1;
        end
        s_tvalid <= 1'b0;

        while (pending_words != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/sha256_pkg.sv
rtl/core/sha256_round.sv
rtl/core/sha256_message_hasher.sv
dv/sha256_digest_checker.sv
dv/tb.sv
